/* hw/rtl/rlrp_pkg.sv */
// ----------------------------------------------------------------------------
// rlrp_pkg
// Shared types, constants and the sine sample function for the RL load and
// relay plant model.
// ----------------------------------------------------------------------------
package rlrp_pkg;

    // Default number of sine samples per period
    localparam int SINE_STEPS_DEFAULT = 1024;

    // Field widths
    localparam int PWM_W     = 8;
    localparam int VOLT_W    = 18;
    localparam int CUR_W     = 32;
    localparam int COEFF_W   = 16;
    localparam int DCV_W     = 24;
    localparam int GAIN_W    = 24;
    localparam int THRESH_W  = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RL_COEFF      = 2'd0,
        REG_DC_VOLTAGE    = 2'd1,
        REG_SENSE_GAIN    = 2'd2,
        REG_OFF_THRESHOLD = 2'd3
    } cfg_reg_e;

    localparam logic [COEFF_W-1:0]  RL_COEFF_RST      = 16'd655;
    localparam logic [DCV_W-1:0]    DC_VOLTAGE_RST    = 24'd65536;
    localparam logic [GAIN_W-1:0]   SENSE_GAIN_RST    = 24'd65536;
    localparam logic [THRESH_W-1:0] OFF_THRESHOLD_RST = 16'd655;

    // Sine generation constants (Q30)
    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
    localparam logic [63:0] SQRT2_Q30  = 64'd1518500250;
    localparam logic [63:0] VOLT_MAX   = 64'd92682;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef struct packed {
        logic                   en;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } rlrp_cfg_wr_t;

    // Shared multiplier operand selection
    typedef enum logic [2:0] {
        MUL_PWM_DC,
        MUL_DIFF_LO,
        MUL_DIFF_HI,
        MUL_CUR_LO,
        MUL_CUR_HI
    } mul_sel_e;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD17
    } acc_op_e;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_e mul_sel;
        acc_op_e  acc_op;
        logic     diff_load;
        logic     cur_update;
        logic     tick_end;
        logic     out_load;
    } rlrp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } rlrp_status_t;

    // sqrt(2)*sin of a 32 bit turn fraction, signed Q2.16; evaluated at elaboration
    function automatic logic signed [VOLT_W-1:0] sine_of_turn(logic [31:0] t);
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        theta;
        logic [63:0]        th2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        quad  = t[31:30];
        r     = {34'd0, t[29:0]};
        if (quad[0])
        begin
            r = (64'd1 << 30) - r;
        end
        theta = (r * HALFPI_Q30) >> 30;
        th2   = (theta * theta) >> 30;
        term  = theta;
        sum   = $signed(term);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * th2) >> 30) / TAYLOR_DIV[k-1];
            if (k % 2 == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        v = ($unsigned(sum) * SQRT2_Q30 + (64'd1 << 43)) >> 44;
        if (v > VOLT_MAX)
        begin
            v = VOLT_MAX;
        end
        if (quad[1])
        begin
            v = -v;
        end
        return $signed(v[VOLT_W-1:0]);
    endfunction

endpackage

/* hw/rtl/rlrp_ifs.sv */
// ----------------------------------------------------------------------------
// rlrp channel interfaces
// Valid/ready channels for drive items, results and configuration writes.
// ----------------------------------------------------------------------------
interface rlrp_drive_if;
    logic                                valid;
    logic                                ready;
    logic signed [rlrp_pkg::PWM_W-1:0]   pwm_ref;
    logic                                relay_cmd;

    modport source (output valid, output pwm_ref, output relay_cmd, input ready);
    modport sink   (input valid, input pwm_ref, input relay_cmd, output ready);
endinterface

interface rlrp_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [rlrp_pkg::VOLT_W-1:0]  source_voltage;
    logic signed [rlrp_pkg::CUR_W-1:0]   sensed_current;
    logic                                relay_closed;

    modport source (output valid, output source_voltage, output sensed_current,
                    output relay_closed, input ready);
    modport sink   (input valid, input source_voltage, input sensed_current,
                    input relay_closed, output ready);
endinterface

interface rlrp_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [rlrp_pkg::CFG_INDEX_W-1:0]      index;
    logic [rlrp_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/rlrp_ctrl.sv */
// ----------------------------------------------------------------------------
// rlrp_ctrl
// Tick sequencer: steps the datapath through the current update, relay
// decision and sensed current calculation on one shared multiplier.
// ----------------------------------------------------------------------------
module rlrp_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rlrp_pkg::rlrp_status_t status,
    output rlrp_pkg::rlrp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PD,
        ST_DIFF,
        ST_DLO,
        ST_DHI,
        ST_DACC,
        ST_CUR,
        ST_SLO,
        ST_SHI,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_sel = rlrp_pkg::MUL_PWM_DC;
        cmd.acc_op  = rlrp_pkg::ACC_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_PD;
                end
            end
            ST_PD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rlrp_pkg::MUL_PWM_DC;
                state_next  = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = ST_DLO;
            end
            ST_DLO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rlrp_pkg::MUL_DIFF_LO;
                state_next  = ST_DHI;
            end
            ST_DHI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rlrp_pkg::MUL_DIFF_HI;
                cmd.acc_op  = rlrp_pkg::ACC_LOAD;
                state_next  = ST_DACC;
            end
            ST_DACC:
            begin
                cmd.acc_op = rlrp_pkg::ACC_ADD17;
                state_next = ST_CUR;
            end
            ST_CUR:
            begin
                cmd.cur_update = 1'b1;
                state_next     = ST_SLO;
            end
            ST_SLO:
            begin
                // current is final here: relay decision and phase advance
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = rlrp_pkg::MUL_CUR_LO;
                cmd.tick_end = 1'b1;
                state_next   = ST_SHI;
            end
            ST_SHI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rlrp_pkg::MUL_CUR_HI;
                cmd.acc_op  = rlrp_pkg::ACC_LOAD;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/rlrp_datapath.sv */
// ----------------------------------------------------------------------------
// rlrp_datapath
// Plant state, configuration registers, sine ROM, shared 18x25 multiplier
// with accumulator, and the result register.
// ----------------------------------------------------------------------------
module rlrp_datapath
#(
    parameter int SINE_STEPS = rlrp_pkg::SINE_STEPS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rlrp_pkg::rlrp_cmd_t                  cmd,
    output rlrp_pkg::rlrp_status_t               status,
    input  rlrp_pkg::rlrp_cfg_wr_t               cfg_wr,
    input  logic signed [rlrp_pkg::PWM_W-1:0]    pwm_ref,
    input  logic                                 relay_cmd,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rlrp_pkg::VOLT_W-1:0]   source_voltage,
    output logic signed [rlrp_pkg::CUR_W-1:0]    sensed_current,
    output logic                                 relay_closed
);

    localparam int PHASE_W = $clog2(SINE_STEPS);
    localparam int A_W     = 18;
    localparam int B_W     = 25;
    localparam int PROD_W  = A_W + B_W;
    localparam int DIFF_W  = 34;
    localparam int ACC_W   = 57;
    localparam int SUM_W   = 36;
    localparam int SAT_W   = 41;

    typedef logic signed [rlrp_pkg::VOLT_W-1:0] sine_rom_t [SINE_STEPS];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] t;
        for (int p = 0; p < SINE_STEPS; p++)
        begin
            t      = (64'(p) << 32) / SINE_STEPS;
            rom[p] = rlrp_pkg::sine_of_turn(t[31:0]);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    function automatic logic signed [rlrp_pkg::CUR_W-1:0] sat32(logic signed [SAT_W-1:0] x);
        logic signed [rlrp_pkg::CUR_W-1:0] y;
        if (x > 41'sd2147483647)
        begin
            y = 32'sh7FFF_FFFF;
        end
        else if (x < -41'sd2147483648)
        begin
            y = 32'sh8000_0000;
        end
        else
        begin
            y = x[rlrp_pkg::CUR_W-1:0];
        end
        return y;
    endfunction

    // configuration
    logic [rlrp_pkg::COEFF_W-1:0]  coeff_reg;
    logic [rlrp_pkg::DCV_W-1:0]    dcv_reg;
    logic [rlrp_pkg::GAIN_W-1:0]   gain_reg;
    logic [rlrp_pkg::THRESH_W-1:0] thresh_reg;

    // plant state
    logic [PHASE_W-1:0]                 phase_reg;
    logic signed [rlrp_pkg::CUR_W-1:0]  cur_reg;
    logic                               relay_reg;

    // per item working registers
    logic signed [rlrp_pkg::VOLT_W-1:0] rom_q_reg;
    logic signed [rlrp_pkg::PWM_W-1:0]  pwm_reg;
    logic                               cmd_reg;
    logic signed [rlrp_pkg::VOLT_W-1:0] vin_reg;
    logic signed [DIFF_W-1:0]           diff_reg;
    logic signed [PROD_W-1:0]           prod_reg;
    logic signed [ACC_W-1:0]            acc_reg;

    // result register
    logic                               out_valid_reg;
    logic signed [rlrp_pkg::VOLT_W-1:0] volt_out_reg;
    logic signed [rlrp_pkg::CUR_W-1:0]  sense_out_reg;
    logic                               relay_out_reg;

    logic signed [A_W-1:0]              mul_a;
    logic signed [B_W-1:0]              mul_b;
    logic signed [PROD_W-1:0]           prod_next;
    logic signed [SUM_W-1:0]            step;
    logic signed [SUM_W-1:0]            cur_sum;
    logic signed [rlrp_pkg::CUR_W-1:0]  cur_next;
    logic [rlrp_pkg::CUR_W-1:0]         cur_mag;
    logic signed [ACC_W-1:0]            sense_sum;
    logic signed [rlrp_pkg::CUR_W-1:0]  sensed;

    always_comb
    begin
        case (cmd.mul_sel)
            rlrp_pkg::MUL_PWM_DC:
            begin
                mul_a = A_W'(pwm_reg);
                mul_b = $signed({1'b0, dcv_reg});
            end
            rlrp_pkg::MUL_DIFF_LO:
            begin
                mul_a = $signed({1'b0, diff_reg[16:0]});
                mul_b = $signed({9'd0, coeff_reg});
            end
            rlrp_pkg::MUL_DIFF_HI:
            begin
                mul_a = A_W'($signed(diff_reg[DIFF_W-1:17]));
                mul_b = $signed({9'd0, coeff_reg});
            end
            rlrp_pkg::MUL_CUR_LO:
            begin
                mul_a = $signed({2'd0, cur_reg[15:0]});
                mul_b = $signed({1'b0, gain_reg});
            end
            rlrp_pkg::MUL_CUR_HI:
            begin
                mul_a = A_W'($signed(cur_reg[31:16]));
                mul_b = $signed({1'b0, gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // step = floor(diff*coeff / 2^16); arithmetic shift is the floor
    assign step    = SUM_W'(acc_reg >>> 16);
    assign cur_sum = SUM_W'(cur_reg) + step;
    assign cur_next = sat32(SAT_W'(cur_sum));
    assign cur_mag = cur_reg[rlrp_pkg::CUR_W-1] ? $unsigned(-cur_reg) : $unsigned(cur_reg);

    assign sense_sum = acc_reg + (ACC_W'(prod_reg) <<< 16);
    assign sensed    = sat32(SAT_W'(sense_sum >>> 16));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg     <= rlrp_pkg::RL_COEFF_RST;
            dcv_reg       <= rlrp_pkg::DC_VOLTAGE_RST;
            gain_reg      <= rlrp_pkg::SENSE_GAIN_RST;
            thresh_reg    <= rlrp_pkg::OFF_THRESHOLD_RST;
            phase_reg     <= '0;
            cur_reg       <= '0;
            relay_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr.en)
            begin
                unique case (cfg_wr.index)
                    rlrp_pkg::REG_RL_COEFF:
                    begin
                        coeff_reg <= cfg_wr.data[rlrp_pkg::COEFF_W-1:0];
                    end
                    rlrp_pkg::REG_DC_VOLTAGE:
                    begin
                        dcv_reg <= cfg_wr.data[rlrp_pkg::DCV_W-1:0];
                    end
                    rlrp_pkg::REG_SENSE_GAIN:
                    begin
                        gain_reg <= cfg_wr.data[rlrp_pkg::GAIN_W-1:0];
                    end
                    rlrp_pkg::REG_OFF_THRESHOLD:
                    begin
                        thresh_reg <= cfg_wr.data[rlrp_pkg::THRESH_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.cur_update)
            begin
                if (!relay_reg || pwm_reg == '0)
                begin
                    cur_reg <= '0;
                end
                else
                begin
                    cur_reg <= cur_next;
                end
            end

            if (cmd.tick_end)
            begin
                if (cmd_reg)
                begin
                    relay_reg <= 1'b1;
                end
                else if (relay_reg && cur_mag < {16'd0, thresh_reg})
                begin
                    relay_reg <= 1'b0;
                end
                if (phase_reg == PHASE_W'(SINE_STEPS - 1))
                begin
                    phase_reg <= '0;
                end
                else
                begin
                    phase_reg <= phase_reg + PHASE_W'(1);
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[phase_reg];
        if (cmd.capture)
        begin
            pwm_reg <= pwm_ref;
            cmd_reg <= relay_cmd;
            vin_reg <= rom_q_reg;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.diff_load)
        begin
            diff_reg <= DIFF_W'(prod_reg) - DIFF_W'(vin_reg) - DIFF_W'(cur_reg);
        end
        case (cmd.acc_op)
            rlrp_pkg::ACC_LOAD:
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            rlrp_pkg::ACC_ADD17:
            begin
                acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< 17);
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            volt_out_reg  <= vin_reg;
            sense_out_reg <= sensed;
            relay_out_reg <= relay_reg;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign source_voltage  = volt_out_reg;
    assign sensed_current  = sense_out_reg;
    assign relay_closed    = relay_out_reg;

endmodule

/* hw/rtl/rl_load_relay_plant_model.sv */
// ----------------------------------------------------------------------------
// rl_load_relay_plant_model
// RL load with relay, advanced one simulation tick per drive transaction.
//
//   channel  dir  payload                                         width
//   drive    in   pwm_ref, relay_cmd                              8s, 1
//   result   out  source_voltage, sensed_current, relay_closed    18s, 32s, 1
//   cfg      in   index, data                                     2, 24
//
// One drive transaction at a time: the accept cycle plus nine steps, with
// five products taken in turn on one 18x25 multiplier.
// The result register frees the sequencer, so a new drive transaction is
// taken while the previous result still waits; a result stalled for longer
// than one tick holds the sequencer in its last step.
// Reset restores register defaults, zero phase and current, relay open.
// cfg is always ready.
// ----------------------------------------------------------------------------
module rl_load_relay_plant_model
#(
    parameter int SINE_STEPS = rlrp_pkg::SINE_STEPS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    rlrp_drive_if.sink    drive,
    rlrp_result_if.source result,
    rlrp_cfg_if.sink      cfg
);

    rlrp_pkg::rlrp_cmd_t    cmd;
    rlrp_pkg::rlrp_status_t status;
    rlrp_pkg::rlrp_cfg_wr_t cfg_wr;
    logic                   in_ready;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.en    = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;
    assign drive.ready  = in_ready;

    rlrp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (drive.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rlrp_datapath
    #(
        .SINE_STEPS (SINE_STEPS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr         (cfg_wr),
        .pwm_ref        (drive.pwm_ref),
        .relay_cmd      (drive.relay_cmd),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .source_voltage (result.source_voltage),
        .sensed_current (result.sensed_current),
        .relay_closed   (result.relay_closed)
    );

endmodule
